FILE: rtl/kbmt_pkg.sv
// Package for the k-best minimum tracker.
// Holds field widths, register indexes, reset values and the transaction structs.
// No dependencies.
package kbmt_pkg;

  localparam int SampleBits = 48;
  localparam int CountBits  = 8;
  localparam int KBestBits  = 4;
  localparam int MaxBits    = 8;
  localparam int EpsBits    = 16;
  localparam int CfgIdxBits = 2;

  localparam int KMaxDefault = 8;

  localparam logic [CfgIdxBits-1:0] CfgKBest      = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgMaxSamples = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgEpsilon    = 2'd2;

  localparam logic [KBestBits-1:0] KBestReset      = 4'd3;
  localparam logic [MaxBits-1:0]   MaxSamplesReset = 8'd20;
  localparam logic [EpsBits-1:0]   EpsilonReset    = 16'd655;

  localparam logic [CountBits-1:0] CountMax = 8'd255;

  typedef struct packed {
    logic [SampleBits-1:0] sample_cycles;
    logic                  first_sample;
  } kbmt_in_t;

  typedef struct packed {
    logic [SampleBits-1:0] best_value;
    logic [SampleBits-1:0] kth_value;
    logic [CountBits-1:0]  count;
    logic                  converged;
    logic                  done_res;
  } kbmt_out_t;

endpackage

FILE: rtl/k_best_min_tracker.sv
// Top level of the k-best minimum tracker: sorted store, sequencer, tolerance check.
// Depends on kbmt_pkg.
//
// Keeps the k smallest cycle-count samples of a measurement in a small sorted store and
// returns one result per sample: best value, k-th best value, sample count, converged and
// done. The store is a single-read-port memory, so a new or replacing entry moves into
// place one entry per cycle. A sample that is not kept goes through the k-th compare, the
// best read, the k-th read and the finish step before its result is registered; a kept
// sample is first moved into place in the store. The input is ready again in the cycle
// the result appears. One sample is worked on at a time; a finished result waits in an
// output register while the next sample is taken, and the following result stalls in its
// last step for as long as that register is still held.
module k_best_min_tracker #(
  parameter int K_MAX = kbmt_pkg::KMaxDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  kbmt_pkg::kbmt_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kbmt_pkg::kbmt_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kbmt_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [kbmt_pkg::EpsBits-1:0]        cfg_data_i
);
  import kbmt_pkg::*;

  localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int PW = SampleBits + EpsBits;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StCmpKth  = 3'd1;
  localparam logic [2:0] StWalk    = 3'd2;
  localparam logic [2:0] StPlace   = 3'd3;
  localparam logic [2:0] StRdBest  = 3'd4;
  localparam logic [2:0] StRdKth   = 3'd5;
  localparam logic [2:0] StFinish  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [KBestBits-1:0]  cfg_kbest_q;
  logic [MaxBits-1:0]    cfg_max_q;
  logic [EpsBits-1:0]    cfg_eps_q;
  logic [CountBits-1:0]  count_q, count_d;
  logic [CountBits-1:0]  k_q, k_d;
  logic [KW-1:0]         pos_q, pos_d;
  logic [SampleBits-1:0] val_q, val_d;
  logic [SampleBits-1:0] best_q, best_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic                  out_valid_q, out_valid_d;
  kbmt_out_t             out_data_q, out_data_d;

  logic [SampleBits-1:0] mem_q [K_MAX];
  logic [SampleBits-1:0] rdata_q;
  logic [KW-1:0]         rd_addr;
  logic                  wr_en;
  logic [KW-1:0]         wr_addr;
  logic [SampleBits-1:0] wr_data;

  logic                  in_fire;
  logic [CountBits-1:0]  k_eff;
  logic [CountBits-1:0]  cnt_pre;
  logic [KW-1:0]         pos_in;
  logic [SampleBits-1:0] scale;
  logic [SampleBits-1:0] diff;
  logic                  have_k;
  logic                  conv;
  logic                  emit;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    priority if (cfg_kbest_q == '0) begin
      k_eff = CountBits'(1);
    end else if (int'(cfg_kbest_q) > K_MAX) begin
      k_eff = CountBits'(K_MAX);
    end else begin
      k_eff = CountBits'(cfg_kbest_q);
    end
  end

  assign cnt_pre = in_data_i.first_sample ? '0 : count_q;
  assign pos_in  = cnt_pre[KW-1:0];

  assign prod_d = (state_q == StRdKth) ?
                  {{EpsBits{1'b0}}, rdata_q} * {{SampleBits{1'b0}}, cfg_eps_q} : prod_q;
  assign scale  = prod_q[PW-1:EpsBits];
  assign diff   = rdata_q - best_q;
  assign have_k = (count_q >= k_q);
  assign conv   = have_k && ((rdata_q <= best_q) || (scale >= diff));
  assign emit   = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    pos_d       = pos_q;
    val_d       = val_q;
    best_d      = best_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          val_d   = in_data_i.sample_cycles;
          k_d     = k_eff;
          count_d = (cnt_pre == CountMax) ? cnt_pre : cnt_pre + CountBits'(1);
          if (cnt_pre < k_eff) begin
            pos_d   = pos_in;
            rd_addr = pos_in - KW'(1);
            state_d = (pos_in == '0) ? StPlace : StWalk;
          end else begin
            rd_addr = KW'(k_eff - CountBits'(1));
            state_d = StCmpKth;
          end
        end
      end
      StCmpKth: begin
        if (val_q < rdata_q) begin
          pos_d   = KW'(k_q - CountBits'(1));
          rd_addr = KW'(k_q - CountBits'(2));
          state_d = (k_q == CountBits'(1)) ? StPlace : StWalk;
        end else begin
          state_d = StRdBest;
        end
      end
      StWalk: begin
        rd_addr = pos_q - KW'(2);
        if (rdata_q > val_q) begin
          wr_en   = 1'b1;
          wr_data = rdata_q;
          pos_d   = pos_q - KW'(1);
          state_d = (pos_q == KW'(1)) ? StPlace : StWalk;
        end else begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        wr_en   = 1'b1;
        state_d = StRdBest;
      end
      StRdBest: begin
        rd_addr = '0;
        state_d = StRdKth;
      end
      StRdKth: begin
        rd_addr = KW'(k_q - CountBits'(1));
        best_d  = rdata_q;
        state_d = StFinish;
      end
      StFinish: begin
        rd_addr = KW'(k_q - CountBits'(1));
        if (emit) begin
          out_valid_d           = 1'b1;
          out_data_d.best_value = best_q;
          out_data_d.kth_value  = have_k ? rdata_q : '0;
          out_data_d.count      = count_q;
          out_data_d.converged  = conv;
          out_data_d.done_res   = conv || (count_q >= cfg_max_q);
          state_d               = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cfg_kbest_q <= KBestReset;
      cfg_max_q   <= MaxSamplesReset;
      cfg_eps_q   <= EpsilonReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgKBest:      cfg_kbest_q <= cfg_data_i[KBestBits-1:0];
          CfgMaxSamples: cfg_max_q   <= cfg_data_i[MaxBits-1:0];
          CfgEpsilon:    cfg_eps_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    best_q     <= best_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  a_walk_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> pos_q != '0)
    else $error("store walk entered at entry zero");

  a_walk_pos_in_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> CountBits'(pos_q) < k_q)
    else $error("store walk position beyond k");

  a_count_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> count_q != '0)
    else $error("sample count zero after transaction");

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.converged |-> out_data_o.done_res)
    else $error("converged result not marked done");

endmodule
